// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the table segment parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/jtsp_pkg.sv
// Types and constants for the JPEG table segment parser
package jtsp_pkg;

    localparam int unsigned NUM_TABLES    = 4;
    localparam int unsigned COUNT_ENTRIES = 16;
    localparam int unsigned QUANT_ENTRIES = 64;
    localparam int unsigned ID_W          = 4;

    // Write targets as seen on the result channel
    localparam logic [1:0] TGT_COUNTS  = 2'd0;
    localparam logic [1:0] TGT_SYMBOLS = 2'd1;
    localparam logic [1:0] TGT_QUANT   = 2'd2;

    typedef enum logic [2:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_HEADER,
        PH_COUNTS,
        PH_SYMBOLS,
        PH_Q_FIRST,
        PH_Q_SECOND,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERRUN,
        ST_BAD_HEADER
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_COUNT,
        OP_SYMBOL,
        OP_QUANT
    } op_kind_t;

    // Classified transaction passed from the front end to the back end
    typedef struct packed {
        op_kind_t    kind;
        logic        cls;
        logic [1:0]  id;
        logic [7:0]  index;
        logic [15:0] value;
        logic        done;
        status_t     status;
    } op_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: hw/rtl/jtsp_byte_if.sv
// Input channel: one segment payload byte per transaction
interface jtsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       func;
    logic       seg_start;

    modport source (output valid, data_byte, func, seg_start, input ready);
    modport sink   (input valid, data_byte, func, seg_start, output ready);
endinterface

// File: hw/rtl/jtsp_write_if.sv
// Result channel: one table write / segment status per transaction
interface jtsp_write_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [1:0]  write_target;
    logic        table_class;
    logic [1:0]  table_id;
    logic [7:0]  entry_index;
    logic [15:0] entry_value;
    logic        seg_done;
    logic [1:0]  status;

    modport source (output valid, write_valid, write_target, table_class, table_id,
                    entry_index, entry_value, seg_done, status, input ready);
    modport sink   (input valid, write_valid, write_target, table_class, table_id,
                    entry_index, entry_value, seg_done, status, output ready);
endinterface

// File: hw/rtl/jpeg_table_segment_parser.sv
// JPEG DHT/DQT segment parser top level
//
//  channel      dir  transaction             payload
//  byte_chan    in   one segment byte        data_byte[8], func, seg_start
//  result_chan  out  one result per byte     write_valid, write_target[2],
//                                            table_class, table_id[2],
//                                            entry_index[8], entry_value[16],
//                                            seg_done, status[2]
//
//  One byte is taken every cycle while the queue is not full; the parse state
//  machine in the front end updates all its counters in the cycle the byte is taken.
//  A result reaches result_chan through the queue, written at the accepting edge,
//  and then the output register, which loads when it is empty or its result is taken.
//  Reset is asynchronous, active low, and leaves the parser waiting for a
//  length high byte; no clearing pass is needed.
//  A stalled result channel fills the queue, after which byte_chan.ready drops.
module jpeg_table_segment_parser #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    jtsp_byte_if.sink    byte_chan,
    jtsp_write_if.source result_chan
);
    import jtsp_pkg::*;

    op_t     push_op, head_op;
    q_stat_t stat;
    logic    push, pop;

    jtsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .stat      (stat),
        .push      (push),
        .op        (push_op)
    );

    jtsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_op),
        .pop       (pop),
        .head      (head_op),
        .stat      (stat)
    );

    jtsp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_op),
        .stat        (stat),
        .pop         (pop),
        .result_chan (result_chan)
    );

endmodule

// File: hw/rtl/jtsp_front.sv
// Front end: segment parse state machine that classifies each byte
`include "assert_macros.svh"

module jtsp_front (
    input  logic             clk,
    input  logic             rst_n,
    jtsp_byte_if.sink        byte_chan,
    input  jtsp_pkg::q_stat_t stat,
    output logic             push,
    output jtsp_pkg::op_t    op
);
    import jtsp_pkg::*;

    phase_t          phase_reg, phase_next, phase_step, eff_phase;
    logic [15:0]     len_reg, len_next, len_lo_value;
    logic [15:0]     seen_reg, seen_next, seen_inc;
    logic            class_reg, class_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic            wide_reg, wide_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [11:0]     total_reg, total_next, total_sum;
    logic [7:0]      held_reg, held_next;
    logic [7:0]      b;
    logic            accept, seg_end, id_ok, hdr_bad;

    assign b            = byte_chan.data_byte;
    assign accept       = byte_chan.valid && byte_chan.ready;
    assign byte_chan.ready = !stat.full;
    assign push         = accept;
    assign eff_phase    = byte_chan.seg_start ? PH_LEN_HI : phase_reg;
    assign len_lo_value = {len_reg[15:8], b};
    assign seen_inc     = seen_reg + 16'd1;
    assign total_sum    = total_reg + {4'h0, b};
    assign id_ok        = {1'b0, id_reg} < 5'(NUM_TABLES);
    assign hdr_bad      = (b[7:4] > 4'd1) || ({1'b0, b[3:0]} >= 5'(NUM_TABLES));

    // Next state of the parser
    always_comb
    begin
        phase_step = phase_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        class_next = class_reg;
        id_next    = id_reg;
        wide_next  = wide_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        held_next  = held_reg;
        seg_end    = 1'b0;
        if (accept)
        begin
            case (eff_phase)
                PH_IDLE:
                begin
                    // drop bytes until the next segment starts
                end
                PH_LEN_HI:
                begin
                    len_next   = {b, 8'h00};
                    seen_next  = 16'd1;
                    phase_step = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = len_lo_value;
                    seen_next  = 16'd2;
                    phase_step = (len_lo_value <= 16'd2) ? PH_IDLE : PH_HEADER;
                end
                default:
                begin
                    seen_next = seen_inc;
                    case (eff_phase)
                        PH_HEADER:
                        begin
                            id_next  = b[3:0];
                            cnt_next = 8'd0;
                            if (!byte_chan.func)
                            begin
                                class_next = b[4];
                                wide_next  = 1'b0;
                                total_next = 12'd0;
                                phase_step = PH_COUNTS;
                            end
                            else
                            begin
                                class_next = 1'b0;
                                wide_next  = b[4];
                                phase_step = PH_Q_FIRST;
                            end
                        end
                        PH_COUNTS:
                        begin
                            total_next = total_sum;
                            cnt_next   = cnt_reg + 8'd1;
                            if (cnt_reg == 8'(COUNT_ENTRIES - 1))
                            begin
                                cnt_next   = 8'd0;
                                phase_step = (total_sum == 12'd0) ? PH_HEADER : PH_SYMBOLS;
                            end
                        end
                        PH_SYMBOLS:
                        begin
                            cnt_next   = cnt_reg + 8'd1;
                            total_next = total_reg - 12'd1;
                            if (total_reg == 12'd1)
                                phase_step = PH_HEADER;
                        end
                        PH_Q_FIRST, PH_Q_SECOND:
                        begin
                            if (eff_phase == PH_Q_FIRST && wide_reg)
                            begin
                                held_next  = b;
                                phase_step = PH_Q_SECOND;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg + 8'd1;
                                phase_step = PH_Q_FIRST;
                                if (cnt_reg == 8'(QUANT_ENTRIES - 1))
                                begin
                                    cnt_next   = 8'd0;
                                    phase_step = PH_HEADER;
                                end
                            end
                        end
                        default:
                        begin
                            phase_step = eff_phase;
                        end
                    endcase
                    seg_end = (seen_inc >= len_reg);
                end
            endcase
        end
        phase_next = seg_end ? PH_IDLE : phase_step;
    end

    // Classify the byte into a queue transaction
    always_comb
    begin
        op        = '0;
        op.kind   = OP_NONE;
        op.status = ST_OK;
        case (eff_phase)
            PH_IDLE, PH_LEN_HI:
            begin
                op.done = 1'b0;
            end
            PH_LEN_LO:
            begin
                op.done   = (len_lo_value <= 16'd2);
                op.status = (len_lo_value < 16'd2) ? ST_OVERRUN : ST_OK;
            end
            default:
            begin
                case (eff_phase)
                    PH_HEADER:
                    begin
                        if (hdr_bad)
                            op.status = ST_BAD_HEADER;
                    end
                    PH_COUNTS, PH_SYMBOLS:
                    begin
                        if (id_ok)
                        begin
                            op.kind  = (eff_phase == PH_COUNTS) ? OP_COUNT : OP_SYMBOL;
                            op.cls   = class_reg;
                            op.id    = id_reg[1:0];
                            op.index = cnt_reg;
                            op.value = {8'h00, b};
                        end
                    end
                    PH_Q_FIRST, PH_Q_SECOND:
                    begin
                        if (id_ok && !(eff_phase == PH_Q_FIRST && wide_reg))
                        begin
                            op.kind  = OP_QUANT;
                            op.id    = id_reg[1:0];
                            op.index = cnt_reg;
                            op.value = (eff_phase == PH_Q_SECOND) ? {held_reg, b}
                                                                  : {8'h00, b};
                        end
                    end
                    default:
                    begin
                        op.kind = OP_NONE;
                    end
                endcase
                // end of segment: overrun unless it falls on a table boundary
                if (seg_end)
                begin
                    op.done = 1'b1;
                    if (phase_step != PH_HEADER)
                        op.status = ST_OVERRUN;
                end
            end
        endcase
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN_HI;
            len_reg   <= '0;
            seen_reg  <= '0;
            class_reg <= 1'b0;
            id_reg    <= '0;
            wide_reg  <= 1'b0;
            cnt_reg   <= '0;
            total_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            wide_reg  <= wide_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            held_reg  <= held_next;
        end
    end

    `ASSERT_IMPLIES(a_count_range, phase_reg == PH_COUNTS, cnt_reg < 8'(COUNT_ENTRIES), "count index past sixteen")
    `ASSERT_IMPLIES(a_symbols_left, phase_reg == PH_SYMBOLS, total_reg != 12'd0, "symbol phase with nothing left")
    `ASSERT_IMPLIES(a_second_wide, phase_reg == PH_Q_SECOND, wide_reg, "second quantizer byte on narrow table")
    `ASSERT_NEXT(a_done_idle, accept && op.done, phase_reg == PH_IDLE, "segment end did not idle the parser")

endmodule

// File: hw/rtl/jtsp_queue.sv
// Short queue between the front end and the back end
`include "assert_macros.svh"

module jtsp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jtsp_pkg::op_t     push_data,
    input  logic              pop,
    output jtsp_pkg::op_t     head,
    output jtsp_pkg::q_stat_t stat
);
    import jtsp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    op_t              slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head       = slots_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed transaction
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_IMPLIES(a_no_overflow, push, !stat.full, "push into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, pop, !stat.empty, "pop from an empty queue")
    `ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count past depth")

endmodule

// File: hw/rtl/jtsp_back.sv
// Back end: format queued transactions into the registered result channel
module jtsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  jtsp_pkg::op_t     head,
    input  jtsp_pkg::q_stat_t stat,
    output logic              pop,
    jtsp_write_if.source      result_chan
);
    import jtsp_pkg::*;

    logic        out_valid_reg;
    logic        load;
    logic        write_valid_reg;
    logic [1:0]  write_target_reg, target;
    logic        table_class_reg;
    logic [1:0]  table_id_reg;
    logic [7:0]  entry_index_reg;
    logic [15:0] entry_value_reg;
    logic        seg_done_reg;
    status_t     status_reg;

    assign load = !out_valid_reg || result_chan.ready;
    assign pop  = load && !stat.empty;

    // Map the transaction kind to a write target
    always_comb
    begin
        case (head.kind)
            OP_COUNT:  target = TGT_COUNTS;
            OP_SYMBOL: target = TGT_SYMBOLS;
            OP_QUANT:  target = TGT_QUANT;
            default:   target = TGT_COUNTS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= !stat.empty;
    end

    // Load the output stage when it drains
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            write_valid_reg  <= (head.kind != OP_NONE);
            write_target_reg <= target;
            table_class_reg  <= head.cls;
            table_id_reg     <= head.id;
            entry_index_reg  <= head.index;
            entry_value_reg  <= head.value;
            seg_done_reg     <= head.done;
            status_reg       <= head.status;
        end
    end

    assign result_chan.valid        = out_valid_reg;
    assign result_chan.write_valid  = write_valid_reg;
    assign result_chan.write_target = write_target_reg;
    assign result_chan.table_class  = table_class_reg;
    assign result_chan.table_id     = table_id_reg;
    assign result_chan.entry_index  = entry_index_reg;
    assign result_chan.entry_value  = entry_value_reg;
    assign result_chan.seg_done     = seg_done_reg;
    assign result_chan.status       = status_reg;

endmodule
